[rtl/core/mcs_pkg.sv]
package mcs_pkg;
    localparam int MAX_NODES = 64;
    localparam int FRAC_BITS = 20;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int VAL_W = 52;
    localparam int NUM_W = 32 + CNT_W + FRAC_BITS + 1;
    localparam int QB_W = $clog2(NUM_W + 1);

    localparam logic [0:0] KIND_LOAD = 1'b0;
    localparam logic [0:0] KIND_START = 1'b1;

    localparam logic [0:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [0:0] CFG_VOLUME = 1'b1;

    typedef struct packed {
        logic search_start;
        logic div_start;
    } mcs_cmd_t;

    typedef struct packed {
        logic search_done;
        logic div_done;
    } mcs_status_t;
endpackage

[rtl/core/mcs_datapath.sv]
module mcs_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcs_pkg::mcs_cmd_t          cmd,
    output mcs_pkg::mcs_status_t       status,
    input  logic                       load_en,
    input  logic [mcs_pkg::IDX_W-1:0]  load_row,
    input  logic [mcs_pkg::MAX_NODES-1:0] load_bits,
    input  logic [mcs_pkg::CNT_W-1:0]  node_count,
    input  logic [15:0]                volume,
    output logic [mcs_pkg::CNT_W-1:0]  clique_size,
    output logic [mcs_pkg::VAL_W-1:0]  best_value
);
    import mcs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [MAX_NODES-1:0] rd_data;
    logic [IDX_W-1:0]     rd_addr;

    // Saved candidate sets of the levels above the current one.
    logic [MAX_NODES-1:0] stk_mem [MAX_NODES];
    logic [MAX_NODES-1:0] stk_data;
    logic [IDX_W-1:0]     stk_wr_addr, stk_rd_addr;
    logic                 stk_we;

    // Candidate set of the current level.
    logic [MAX_NODES-1:0] cur_reg;
    logic [CNT_W-1:0]     lvl_reg, best_reg, n_reg;
    logic [1:0]           st_reg;
    logic                 sdone_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic                 top_reg;

    logic [MAX_NODES-1:0] nmask, abv;
    logic [IDX_W-1:0]     first;
    logic                 any;
    logic                 bound_fail;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            adj_mem[load_row] <= load_bits;
        end
        rd_data <= adj_mem[rd_addr];
    end

    // Push the rest of the current level on a pick; read the level above for a return.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wr_addr] <= cur_reg & (cur_reg - 1'b1);
        end
        stk_data <= stk_mem[stk_rd_addr];
    end

    always_comb
    begin
        for (int b = 0; b < MAX_NODES; b++)
        begin
            nmask[b] = (CNT_W'(b) < n_reg);
        end
        any = |cur_reg;
        first = '0;
        for (int b = MAX_NODES - 1; b >= 0; b--)
        begin
            if (cur_reg[b])
            begin
                first = IDX_W'(b);
            end
        end
        for (int b = 0; b < MAX_NODES; b++)
        begin
            abv[b] = (b > int'(pick_reg));
        end
    end

    assign rd_addr = first;
    assign bound_fail = ({1'b0, lvl_reg} + (CNT_W+1)'(n_reg) - (CNT_W+1)'(first))
                        < {1'b0, best_reg};
    assign stk_we = (st_reg == S_SCAN) && !top_reg && any && !bound_fail;
    assign stk_wr_addr = lvl_reg[IDX_W-1:0];
    assign stk_rd_addr = lvl_reg[IDX_W-1:0] - 1'b1;

    // Level 0 holds start nodes; a node picked at level L has L+1 members.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            sdone_reg <= 1'b0;
            lvl_reg <= '0;
            best_reg <= '0;
            n_reg <= CNT_W'(1);
            top_reg <= 1'b0;
            cur_reg <= '0;
            pick_reg <= '0;
        end
        else
        begin
            sdone_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd.search_start)
                    begin
                        if (node_count == '0)
                            n_reg <= CNT_W'(1);
                        else if (node_count > CNT_W'(MAX_NODES))
                            n_reg <= CNT_W'(MAX_NODES);
                        else
                            n_reg <= node_count;
                        best_reg <= '0;
                        lvl_reg <= '0;
                        top_reg <= 1'b1;
                        st_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (top_reg)
                    begin
                        cur_reg <= nmask;
                        top_reg <= 1'b0;
                    end
                    else if (!any || bound_fail)
                    begin
                        // level exhausted or bound fails: abandon this level
                        if (best_reg < lvl_reg)
                            best_reg <= lvl_reg;
                        if (lvl_reg == '0)
                        begin
                            st_reg <= S_IDLE;
                            sdone_reg <= 1'b1;
                        end
                        else
                        begin
                            lvl_reg <= lvl_reg - 1'b1;
                            st_reg <= S_POP;
                        end
                    end
                    else
                    begin
                        pick_reg <= first;
                        st_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    cur_reg <= cur_reg & rd_data & abv & ((lvl_reg == '0) ? nmask : '1);
                    lvl_reg <= lvl_reg + 1'b1;
                    st_reg <= S_SCAN;
                end
                S_POP:
                begin
                    cur_reg <= stk_data;
                    st_reg <= S_SCAN;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Restoring divider: (k^2*(m-1) << F + m) / (2m).
    logic [NUM_W-1:0]      dq_reg, drem_reg;
    logic [CNT_W:0]        dden_reg;
    logic [QB_W-1:0]       dcnt_reg;
    logic                  dbusy_reg, ddone_reg;
    logic [31:0]           k2_reg;
    logic [NUM_W:0]        trial;
    logic [32+CNT_W-1:0]   dprod;

    assign trial = {drem_reg, dq_reg[NUM_W-1]} - (NUM_W+1)'(dden_reg);
    assign dprod = (32+CNT_W)'(k2_reg) * (32+CNT_W)'(best_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg <= '0;
            dq_reg <= '0;
            drem_reg <= '0;
            dden_reg <= '0;
            k2_reg <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                k2_reg <= 32'(volume) * 32'(volume);
                dbusy_reg <= 1'b1;
                dcnt_reg <= '1;
            end
            else if (dbusy_reg && dcnt_reg == '1)
            begin
                dq_reg <= NUM_W'({dprod, {FRAC_BITS{1'b0}}}) + NUM_W'(best_reg);
                drem_reg <= '0;
                dden_reg <= {best_reg, 1'b0};
                dcnt_reg <= QB_W'(NUM_W);
            end
            else if (dbusy_reg)
            begin
                if (!trial[NUM_W])
                begin
                    drem_reg <= trial[NUM_W-1:0];
                    dq_reg <= {dq_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[NUM_W-2:0], dq_reg[NUM_W-1]};
                    dq_reg <= {dq_reg[NUM_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == QB_W'(1))
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    assign status.search_done = sdone_reg;
    assign status.div_done = ddone_reg;
    assign clique_size = best_reg;
    assign best_value = (|dq_reg[NUM_W-1:VAL_W]) ? '1 : dq_reg[VAL_W-1:0];
endmodule

[rtl/core/mcs_ctrl.sv]
module mcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_taken,
    output mcs_pkg::mcs_cmd_t    cmd,
    input  mcs_pkg::mcs_status_t status
);
    import mcs_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_SRCH = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;
    localparam logic [1:0] C_OUT  = 2'd3;

    logic [1:0] st_reg, st_next;

    always_comb
    begin
        st_next = st_reg;
        cmd.search_start = 1'b0;
        cmd.div_start = 1'b0;
        case (st_reg)
            C_IDLE:
                if (start)
                begin
                    cmd.search_start = 1'b1;
                    st_next = C_SRCH;
                end
            C_SRCH:
                if (status.search_done)
                begin
                    cmd.div_start = 1'b1;
                    st_next = C_DIV;
                end
            C_DIV:
                if (status.div_done)
                    st_next = C_OUT;
            C_OUT:
                if (res_taken)
                    st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= C_IDLE;
        else
            st_reg <= st_next;
    end

    assign busy = (st_reg != C_IDLE);
    assign res_valid = (st_reg == C_OUT);
endmodule

[rtl/core/max_clique_search_top.sv]
// Operation: a search descends through the scan and read states and returns
// through the scan and pop states of the backtracking, then the result
// divider runs before the result item is offered.
// Throughput: one row load per cycle; one search at a time, loads held off
// while a search or its result is pending.
// Reset: asynchronous active low; idles control, sets node_count and volume to 1.
module max_clique_search_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: row_index [5:0], row_bits [69:6], zero pad [71:70]
    input  logic [71:0] s_tdata,
    // tuser: kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: clique_size [6:0], best_value [58:7], zero pad [63:59]
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import mcs_pkg::*;

    logic [CNT_W-1:0] node_count_reg;
    logic [15:0]      volume_reg;
    logic             busy, res_valid, s_acc;
    mcs_cmd_t         cmd;
    mcs_status_t      status;
    logic [CNT_W-1:0] clique_size;
    logic [VAL_W-1:0] best_value;

    // Hold configuration; the user must write it only while idle, the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(1);
            volume_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NODE_COUNT)
                node_count_reg <= cfg_data[CNT_W-1:0];
            else
                volume_reg <= cfg_data;
        end
    end

    assign s_tready = !busy;
    assign s_acc = s_tvalid && s_tready;

    mcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_acc && s_tuser == KIND_START),
        .busy      (busy),
        .res_valid (res_valid),
        .res_taken (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    mcs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .load_en     (s_acc && s_tuser == KIND_LOAD),
        .load_row    (s_tdata[IDX_W-1:0]),
        .load_bits   (s_tdata[IDX_W +: MAX_NODES]),
        .node_count  (node_count_reg),
        .volume      (volume_reg),
        .clique_size (clique_size),
        .best_value  (best_value)
    );

    assign m_tvalid = res_valid;
    assign m_tdata = {5'd0, best_value, clique_size};

`ifndef SYNTHESIS
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_tready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_size_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] != 7'd0) else $error("empty clique");
`endif
endmodule
